### hdl/rsi_pkg.sv
// ----------------------------------------------------------------------------
// rsi_pkg: shared types for the ray-sphere intersection core
// Holds the control word that walks down the cell chains with each ray.
// ----------------------------------------------------------------------------
package rsi_pkg;

  // Control word carried alongside every ray through the pipeline
  typedef struct packed {
    logic valid;
    logic hit;
  } rsi_ctrl_t;

endpackage

### hdl/rsi_sqrt_cell.sv
// ----------------------------------------------------------------------------
// rsi_sqrt_cell: one digit cell of the square-root chain
// Retires one root bit per cell (two radicand bits) and registers the result.
// ----------------------------------------------------------------------------
module rsi_sqrt_cell import rsi_pkg::*; #(
  parameter int unsigned SW = 50,
  parameter int unsigned PW = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  rsi_ctrl_t         ctrl_i,
  input  logic [2*SW-1:0]   rad_i,
  input  logic [SW+1:0]     rem_i,
  input  logic [SW-1:0]     root_i,
  input  logic [PW-1:0]     pay_i,
  output rsi_ctrl_t         ctrl_o,
  output logic [2*SW-1:0]   rad_o,
  output logic [SW+1:0]     rem_o,
  output logic [SW-1:0]     root_o,
  output logic [PW-1:0]     pay_o
);

  logic [SW+3:0] rem_x;
  logic [SW+1:0] rem_sh;
  logic [SW+1:0] trial;
  logic [SW+1:0] diff;
  logic          ge;

  // Bring down the next two radicand bits and try the new root bit
  always_comb begin
    rem_x  = {rem_i, rad_i[2*SW-1 -: 2]};
    rem_sh = rem_x[SW+1:0];
    trial  = {root_i, 2'b01};
    diff   = rem_sh - trial;
    ge     = (rem_sh >= trial);
  end

  // Hold control under reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_o <= '0;
    end else if (en_i) begin
      ctrl_o <= ctrl_i;
    end
  end

  // Advance the partial root and remainder
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_o  <= ge ? diff : rem_sh;
      root_o <= {root_i[SW-2:0], ge};
      rad_o  <= {rad_i[2*SW-3:0], 2'b00};
      pay_o  <= pay_i;
    end
  end

endmodule

### hdl/rsi_div_cell.sv
// ----------------------------------------------------------------------------
// rsi_div_cell: one bit cell of the restoring divider chain
// Produces one quotient bit per cell and registers the partial remainder.
// ----------------------------------------------------------------------------
module rsi_div_cell import rsi_pkg::*; #(
  parameter int unsigned AW = 48,
  parameter int unsigned NB = 24,
  parameter int unsigned PW = 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  rsi_ctrl_t      ctrl_i,
  input  logic [AW-1:0]  rem_i,
  input  logic [NB-1:0]  num_i,
  input  logic [NB-1:0]  quo_i,
  input  logic [AW-1:0]  den_i,
  input  logic [PW-1:0]  pay_i,
  output rsi_ctrl_t      ctrl_o,
  output logic [AW-1:0]  rem_o,
  output logic [NB-1:0]  num_o,
  output logic [NB-1:0]  quo_o,
  output logic [AW-1:0]  den_o,
  output logic [PW-1:0]  pay_o
);

  logic [AW:0] rem_sh;
  logic [AW:0] diff;
  logic        ge;

  // Shift in the next numerator bit and compare against the divisor
  always_comb begin
    rem_sh = {rem_i, num_i[NB-1]};
    diff   = rem_sh - {1'b0, den_i};
    ge     = (rem_sh >= {1'b0, den_i});
  end

  // Hold control under reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_o <= '0;
    end else if (en_i) begin
      ctrl_o <= ctrl_i;
    end
  end

  // Advance remainder and quotient
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_o <= ge ? diff[AW-1:0] : rem_sh[AW-1:0];
      quo_o <= {quo_i[NB-2:0], ge};
      num_o <= {num_i[NB-2:0], 1'b0};
      den_o <= den_i;
      pay_o <= pay_i;
    end
  end

endmodule

### hdl/ray_sphere_intersect_core.sv
// ----------------------------------------------------------------------------
// ray_sphere_intersect_core: fixed-point ray against sphere hit test
// Solves the ray-sphere quadratic and returns the nearer root.
// ----------------------------------------------------------------------------
// One ray is taken every clock cycle while the skid register is empty. Each
// result passes through the product and sum stages, one square-root cell per
// root bit (2*COORD_WIDTH+2 cells), the numerator registers, one divider cell
// per result bit (COORD_WIDTH cells) and the output register. A result that is
// not taken parks in a skid register, after which the input stops taking words
// until the output drains. A zero direction or a negative discriminant gives
// hit = 0 and distance = 0; a root beyond the signed range saturates and sets
// overflow.
module ray_sphere_intersect_core import rsi_pkg::*; #(
  parameter int unsigned COORD_WIDTH = 24,
  parameter int unsigned FRAC_BITS   = 12
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [COORD_WIDTH-1:0] origin_x_i,
  input  logic signed [COORD_WIDTH-1:0] origin_y_i,
  input  logic signed [COORD_WIDTH-1:0] origin_z_i,
  input  logic signed [COORD_WIDTH-1:0] dir_x_i,
  input  logic signed [COORD_WIDTH-1:0] dir_y_i,
  input  logic signed [COORD_WIDTH-1:0] dir_z_i,
  input  logic signed [COORD_WIDTH-1:0] center_x_i,
  input  logic signed [COORD_WIDTH-1:0] center_y_i,
  input  logic signed [COORD_WIDTH-1:0] center_z_i,
  input  logic        [COORD_WIDTH-2:0] radius_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          hit_o,
  output logic signed [COORD_WIDTH-1:0] distance_o,
  output logic                          overflow_o
);

  localparam int unsigned W   = COORD_WIDTH;
  localparam int unsigned OCW = W + 1;
  localparam int unsigned AW  = 2 * W;
  localparam int unsigned HW  = 2 * W + 2;
  localparam int unsigned KW  = 2 * W + 3;
  localparam int unsigned HMW = 2 * W + 1;
  localparam int unsigned KMW = 2 * W + 2;
  localparam int unsigned LO  = W + 1;
  localparam int unsigned PPW = 2 * LO;
  localparam int unsigned PQW = 4 * W + 2;
  localparam int unsigned QW  = 4 * W + 4;
  localparam int unsigned SW  = 2 * W + 2;
  localparam int unsigned NW  = 2 * W + 4;
  localparam int unsigned MW  = NW - 1 + FRAC_BITS;
  localparam int unsigned CW  = (MW > AW + W) ? MW : AW + W;
  localparam int unsigned SPW = HW + AW;

  logic en;

  // --------------------------------------------------------------------------
  // Stage 1: offset from centre
  // --------------------------------------------------------------------------
  logic                  v1_q;
  logic signed [OCW-1:0] oc_q [3];
  logic signed [W-1:0]   d_q  [3];
  logic        [W-2:0]   r_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      oc_q[0] <= OCW'(origin_x_i) - OCW'(center_x_i);
      oc_q[1] <= OCW'(origin_y_i) - OCW'(center_y_i);
      oc_q[2] <= OCW'(origin_z_i) - OCW'(center_z_i);
      d_q[0]  <= dir_x_i;
      d_q[1]  <= dir_y_i;
      d_q[2]  <= dir_z_i;
      r_q     <= radius_i;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: component products
  // --------------------------------------------------------------------------
  logic                  v2_q;
  logic signed [2*W-1:0] dd_q [3];
  logic signed [2*W:0]   od_q [3];
  logic signed [2*W+1:0] oo_q [3];
  logic        [2*W-3:0] rr_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        dd_q[i] <= (2*W)'(d_q[i]) * (2*W)'(d_q[i]);
        od_q[i] <= (2*W+1)'(oc_q[i]) * (2*W+1)'(d_q[i]);
        oo_q[i] <= (2*W+2)'(oc_q[i]) * (2*W+2)'(oc_q[i]);
      end
      rr_q <= (2*W-2)'(r_q) * (2*W-2)'(r_q);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: dot products a, h and c
  // --------------------------------------------------------------------------
  logic                 v3_q;
  logic        [AW-1:0] a3_q;
  logic signed [HW-1:0] h3_q;
  logic signed [KW-1:0] k3_q;
  logic signed [AW:0]   a_sum;

  always_comb begin
    a_sum = (AW+1)'(dd_q[0]) + (AW+1)'(dd_q[1]) + (AW+1)'(dd_q[2]);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a3_q <= a_sum[AW-1:0];
      h3_q <= HW'(od_q[0]) + HW'(od_q[1]) + HW'(od_q[2]);
      k3_q <= KW'(oo_q[0]) + KW'(oo_q[1]) + KW'(oo_q[2]) - KW'({1'b0, rr_q});
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: magnitudes for the wide products
  // --------------------------------------------------------------------------
  logic                 v4_q;
  logic        [HMW-1:0] hm4_q;
  logic        [KMW-1:0] km4_q;
  logic                  ks4_q;
  logic        [AW-1:0]  a4_q;
  logic signed [HW-1:0]  h4_q;
  logic signed [HW-1:0]  h_neg;
  logic signed [KW-1:0]  k_neg;

  always_comb begin
    h_neg = -h3_q;
    k_neg = -k3_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hm4_q <= h3_q[HW-1] ? h_neg[HMW-1:0] : h3_q[HMW-1:0];
      km4_q <= k3_q[KW-1] ? k_neg[KMW-1:0] : k3_q[KMW-1:0];
      ks4_q <= k3_q[KW-1];
      a4_q  <= a3_q;
      h4_q  <= h3_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: partial products of h*h and a*|c|
  // --------------------------------------------------------------------------
  logic                 v5_q;
  logic [PPW-1:0]       phh_q, phl_q, pll_q;
  logic [PPW-1:0]       pkhh_q, pkhl_q, pklh_q, pkll_q;
  logic                 ks5_q;
  logic [AW-1:0]        a5_q;
  logic signed [HW-1:0] h5_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      phh_q  <= PPW'(hm4_q[HMW-1:LO]) * PPW'(hm4_q[HMW-1:LO]);
      phl_q  <= PPW'(hm4_q[HMW-1:LO]) * PPW'(hm4_q[LO-1:0]);
      pll_q  <= PPW'(hm4_q[LO-1:0]) * PPW'(hm4_q[LO-1:0]);
      pkhh_q <= PPW'(a4_q[AW-1:LO]) * PPW'(km4_q[KMW-1:LO]);
      pkhl_q <= PPW'(a4_q[AW-1:LO]) * PPW'(km4_q[LO-1:0]);
      pklh_q <= PPW'(a4_q[LO-1:0]) * PPW'(km4_q[KMW-1:LO]);
      pkll_q <= PPW'(a4_q[LO-1:0]) * PPW'(km4_q[LO-1:0]);
      ks5_q  <= ks4_q;
      a5_q   <= a4_q;
      h5_q   <= h4_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 6: assemble h*h and a*|c|
  // --------------------------------------------------------------------------
  logic                 v6_q;
  logic [PQW-1:0]       hh6_q, ak6_q;
  logic                 ks6_q;
  logic [AW-1:0]        a6_q;
  logic signed [HW-1:0] h6_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      hh6_q <= (PQW'(phh_q) << (2*LO)) + (PQW'(phl_q) << (LO+1)) + PQW'(pll_q);
      ak6_q <= (PQW'(pkhh_q) << (2*LO)) + ((PQW'(pkhl_q) + PQW'(pklh_q)) << LO)
             + PQW'(pkll_q);
      ks6_q <= ks5_q;
      a6_q  <= a5_q;
      h6_q  <= h5_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 7: discriminant and hit decision
  // --------------------------------------------------------------------------
  logic                 v7_q;
  logic [QW-1:0]        q7_q;
  logic                 hit7_q;
  logic [AW-1:0]        a7_q;
  logic signed [HW-1:0] h7_q;
  logic [QW-1:0]        disc;

  always_comb begin
    disc = ks6_q ? (QW'(hh6_q) + QW'(ak6_q)) : (QW'(hh6_q) - QW'(ak6_q));
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      q7_q   <= disc;
      hit7_q <= (a6_q != '0) && !disc[QW-1];
      a7_q   <= a6_q;
      h7_q   <= h6_q;
    end
  end

  // Valid bits of the front stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
      v7_q <= v6_q;
    end
  end

  // --------------------------------------------------------------------------
  // Square-root chain: one root bit per cell
  // --------------------------------------------------------------------------
  rsi_ctrl_t         sq_ctrl [SW+1];
  logic [2*SW-1:0]   sq_rad  [SW+1];
  logic [SW+1:0]     sq_rem  [SW+1];
  logic [SW-1:0]     sq_root [SW+1];
  logic [SPW-1:0]    sq_pay  [SW+1];

  always_comb begin
    sq_ctrl[0] = '{valid: v7_q, hit: hit7_q};
    sq_rad[0]  = q7_q;
    sq_rem[0]  = '0;
    sq_root[0] = '0;
    sq_pay[0]  = {h7_q, a7_q};
  end

  for (genvar g = 0; g < SW; g++) begin : g_sqrt
    rsi_sqrt_cell #(
      .SW (SW),
      .PW (SPW)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .ctrl_i (sq_ctrl[g]),
      .rad_i  (sq_rad[g]),
      .rem_i  (sq_rem[g]),
      .root_i (sq_root[g]),
      .pay_i  (sq_pay[g]),
      .ctrl_o (sq_ctrl[g+1]),
      .rad_o  (sq_rad[g+1]),
      .rem_o  (sq_rem[g+1]),
      .root_o (sq_root[g+1]),
      .pay_o  (sq_pay[g+1])
    );
  end

  // --------------------------------------------------------------------------
  // Numerator: -h - sqrt, then magnitude scaled by the fraction bits
  // --------------------------------------------------------------------------
  rsi_ctrl_t            n1_ctrl_q, n2_ctrl_q, n3_ctrl_q;
  logic signed [NW-1:0] num1_q;
  logic [AW-1:0]        a1n_q, a2n_q, a3n_q;
  logic                 neg2_q, neg3_q;
  logic [NW-2:0]        mag2_q;
  logic signed [NW-1:0] num_neg;
  logic [MW-1:0]        magf;
  logic [CW-1:0]        magf_w;
  logic [CW-1:0]        lim_w;
  logic [AW-1:0]        rem0_q;
  logic [W-1:0]         lo3_q;
  logic                 big3_q;

  always_comb begin
    num_neg = -num1_q;
    magf    = {mag2_q, {FRAC_BITS{1'b0}}};
    magf_w  = CW'(magf);
    lim_w   = CW'(a2n_q) << W;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      num1_q <= -NW'($signed(sq_pay[SW][SPW-1:AW])) - NW'({1'b0, sq_root[SW]});
      a1n_q  <= sq_pay[SW][AW-1:0];
      neg2_q <= num1_q[NW-1];
      mag2_q <= num1_q[NW-1] ? num_neg[NW-2:0] : num1_q[NW-2:0];
      a2n_q  <= a1n_q;
      neg3_q <= neg2_q;
      big3_q <= (magf_w >= lim_w);
      rem0_q <= AW'(magf_w >> W);
      lo3_q  <= magf[W-1:0];
      a3n_q  <= a2n_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n1_ctrl_q <= '0;
      n2_ctrl_q <= '0;
      n3_ctrl_q <= '0;
    end else if (en) begin
      n1_ctrl_q <= sq_ctrl[SW];
      n2_ctrl_q <= n1_ctrl_q;
      n3_ctrl_q <= n2_ctrl_q;
    end
  end

  // --------------------------------------------------------------------------
  // Divider chain: one quotient bit per cell
  // --------------------------------------------------------------------------
  rsi_ctrl_t     dv_ctrl [W+1];
  logic [AW-1:0] dv_rem  [W+1];
  logic [W-1:0]  dv_num  [W+1];
  logic [W-1:0]  dv_quo  [W+1];
  logic [AW-1:0] dv_den  [W+1];
  logic [1:0]    dv_pay  [W+1];

  always_comb begin
    dv_ctrl[0] = n3_ctrl_q;
    dv_rem[0]  = rem0_q;
    dv_num[0]  = lo3_q;
    dv_quo[0]  = '0;
    dv_den[0]  = a3n_q;
    dv_pay[0]  = {neg3_q, big3_q};
  end

  for (genvar g = 0; g < W; g++) begin : g_div
    rsi_div_cell #(
      .AW (AW),
      .NB (W),
      .PW (2)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .ctrl_i (dv_ctrl[g]),
      .rem_i  (dv_rem[g]),
      .num_i  (dv_num[g]),
      .quo_i  (dv_quo[g]),
      .den_i  (dv_den[g]),
      .pay_i  (dv_pay[g]),
      .ctrl_o (dv_ctrl[g+1]),
      .rem_o  (dv_rem[g+1]),
      .num_o  (dv_num[g+1]),
      .quo_o  (dv_quo[g+1]),
      .den_o  (dv_den[g+1]),
      .pay_o  (dv_pay[g+1])
    );
  end

  // --------------------------------------------------------------------------
  // Rounding and saturation of the root
  // --------------------------------------------------------------------------
  localparam logic [W-1:0] MaxVal = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MinVal = {1'b1, {(W-1){1'b0}}};

  logic [W:0]   ceil_q;
  logic [W:0]   ceil_neg;
  logic         res_neg, res_big, res_ovf;
  logic [W-1:0] res_dist;

  always_comb begin
    res_neg  = dv_pay[W][1];
    res_big  = dv_pay[W][0];
    ceil_q   = {1'b0, dv_quo[W]} + (W+1)'(dv_rem[W] != '0);
    ceil_neg = -ceil_q;
    res_ovf  = 1'b0;
    res_dist = '0;
    if (dv_ctrl[W].hit) begin
      if (res_neg) begin
        res_ovf  = res_big || (ceil_q > ((W+1)'(1) << (W-1)));
        res_dist = res_ovf ? MinVal : ceil_neg[W-1:0];
      end else begin
        res_ovf  = res_big || dv_quo[W][W-1];
        res_dist = res_ovf ? MaxVal : dv_quo[W];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output register and skid stage
  // --------------------------------------------------------------------------
  logic         out_v_q, skid_v_q;
  logic         skid_hit_q, skid_ovf_q;
  logic [W-1:0] skid_dist_q;
  logic         out_hit_q, out_ovf_q;
  logic [W-1:0] out_dist_q;
  logic         arrive;
  logic         drain;

  assign en     = !skid_v_q;
  assign arrive = en && dv_ctrl[W].valid;
  assign drain  = !out_v_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (drain) begin
      out_v_q  <= skid_v_q || arrive;
      skid_v_q <= 1'b0;
    end else if (arrive) begin
      skid_v_q <= 1'b1;
    end
  end

  // Load the output register, or park a word in skid when stalled
  always_ff @(posedge clk_i) begin
    if (drain) begin
      if (skid_v_q) begin
        out_hit_q  <= skid_hit_q;
        out_ovf_q  <= skid_ovf_q;
        out_dist_q <= skid_dist_q;
      end else begin
        out_hit_q  <= dv_ctrl[W].hit;
        out_ovf_q  <= res_ovf;
        out_dist_q <= res_dist;
      end
    end else if (arrive) begin
      skid_hit_q  <= dv_ctrl[W].hit;
      skid_ovf_q  <= res_ovf;
      skid_dist_q <= res_dist;
    end
  end

  assign in_ready_o  = en;
  assign out_valid_o = out_v_q;
  assign hit_o       = out_hit_q;
  assign overflow_o  = out_ovf_q;
  assign distance_o  = out_dist_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_skid_needs_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid holds a word while the output is empty");

  a_skid_one_cycle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_ready_i && skid_v_q) |=> !skid_v_q && out_v_q)
    else $error("skid word not moved to the output");

  a_miss_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !out_hit_q) |-> (out_dist_q == '0) && !out_ovf_q)
    else $error("miss with nonzero distance or overflow");

  a_ovf_saturated : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_ovf_q) |-> (out_dist_q == MaxVal) || (out_dist_q == MinVal))
    else $error("overflow without a saturated distance");

endmodule

### bench/tb_ray_sphere_intersect_core.sv
// ----------------------------------------------------------------------------
// tb_ray_sphere_intersect_core: self-checking bench for the ray-sphere core
// Drives rays in random bursts against a stalling receiver and predicts
// each hit flag, nearer root and saturation flag with exact wide integers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_ray_sphere_intersect_core;

  localparam int unsigned CW = 24;
  localparam int unsigned FB = 12;
  localparam int unsigned LATENCY = 3 * CW + 13;
  localparam int unsigned RAND_RAYS = 950;

  typedef logic signed [CW-1:0] coord_t;

  typedef struct {
    coord_t ox, oy, oz, dx, dy, dz, cx, cy, cz;
    logic [CW-2:0] rad;
  } ray_t;

  typedef struct {
    logic hit;
    coord_t depth;
    logic ovf;
  } hit_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  coord_t origin_x_i = '0, origin_y_i = '0, origin_z_i = '0;
  coord_t dir_x_i = '0, dir_y_i = '0, dir_z_i = '0;
  coord_t center_x_i = '0, center_y_i = '0, center_z_i = '0;
  logic [CW-2:0] radius_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic hit_o;
  coord_t distance_o;
  logic overflow_o;

  ray_t ray_queue[$];
  hit_t hit_queue[$];
  int   errors = 0;
  int   results_seen = 0;
  int   gap_left = 0;
  int   burst_left = 0;
  int   hold_left = 0;
  bit   hold_done = 1'b0;

  ray_sphere_intersect_core #(.COORD_WIDTH(CW), .FRAC_BITS(FB)) uut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Floor square root of a non-negative 128-bit value
  function automatic logic [127:0] floor_sqrt(input logic [127:0] num);
    logic [127:0] res, bitv, rb;
    res  = '0;
    bitv = 128'd1 << 126;
    while (bitv != 0 && bitv > num) bitv = bitv >> 2;
    while (bitv != 0) begin
      rb = res + bitv;
      if (num >= rb) begin
        num = num - rb;
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Solve the quadratic exactly and saturate the nearer root
  function automatic hit_t nearer_root(input ray_t r);
    logic signed [127:0] ocx, ocy, ocz, dx, dy, dz, a, h, k, q, s, num, t, rem;
    logic signed [127:0] hi, lo;
    hit_t res;
    ocx = 128'(r.ox) - 128'(r.cx);
    ocy = 128'(r.oy) - 128'(r.cy);
    ocz = 128'(r.oz) - 128'(r.cz);
    dx = r.dx; dy = r.dy; dz = r.dz;
    a = dx * dx + dy * dy + dz * dz;
    h = ocx * dx + ocy * dy + ocz * dz;
    k = ocx * ocx + ocy * ocy + ocz * ocz - $signed({105'd0, r.rad}) * $signed({105'd0, r.rad});
    q = h * h - a * k;
    res = '{hit: 1'b0, depth: '0, ovf: 1'b0};
    if (a != 0 && q >= 0) begin
      res.hit = 1'b1;
      s = $signed(floor_sqrt(q));
      num = (-h - s) <<< FB;
      t = num / a;
      rem = num % a;
      // round toward minus infinity
      if (rem != 0 && num < 0) t = t - 1;
      hi = (128'sd1 <<< (CW - 1)) - 1;
      lo = -(128'sd1 <<< (CW - 1));
      if (t > hi) begin
        t = hi;
        res.ovf = 1'b1;
      end else if (t < lo) begin
        t = lo;
        res.ovf = 1'b1;
      end
      res.depth = t[CW-1:0];
    end
    return res;
  endfunction

  function automatic coord_t rand_coord(input int span);
    if (span >= CW) return coord_t'($urandom);
    return coord_t'($signed($urandom_range(0, (1 << span) - 1)) - (1 << (span - 1)));
  endfunction

  function automatic ray_t make_ray(input coord_t ox, oy, oz, dx, dy, dz, cx, cy, cz,
                                    input logic [CW-2:0] rad);
    ray_t r;
    r = '{ox, oy, oz, dx, dy, dz, cx, cy, cz, rad};
    return r;
  endfunction

  // Random ray: mostly small scenes that hit, some fully random words
  function automatic ray_t rand_ray();
    ray_t r;
    int sel, sp, dsp;
    sel = $urandom_range(0, 9);
    sp  = (sel < 2) ? CW : $urandom_range(8, 18);
    dsp = (sel == 2) ? $urandom_range(1, 4) : ((sel < 2) ? CW : $urandom_range(4, 16));
    r.ox = rand_coord(sp); r.oy = rand_coord(sp); r.oz = rand_coord(sp);
    r.dx = rand_coord(dsp); r.dy = rand_coord(dsp); r.dz = rand_coord(dsp);
    if (sel == 3) begin
      r.dx = '0; r.dy = '0; r.dz = '0;
    end
    r.cx = rand_coord(sp); r.cy = rand_coord(sp); r.cz = rand_coord(sp);
    r.rad = (sel < 2) ? (CW-1)'($urandom) : (CW-1)'($urandom_range(0, (1 << sp) - 1));
    return r;
  endfunction

  // Fill the pending rays: directed corners first, then random traffic
  initial begin
    coord_t mx, mn;
    mx = {1'b0, {(CW-1){1'b1}}};
    mn = {1'b1, {(CW-1){1'b0}}};
    // fields at their extremes, then all fields zero
    ray_queue.push_back(make_ray(mx, mx, mx, mx, mx, mx, mn, mn, mn, '1));
    ray_queue.push_back(make_ray(mn, mn, mn, mn, mn, mn, mx, mx, mx, '1));
    ray_queue.push_back(make_ray(mn, mn, mn, mx, mx, mx, mx, mx, mx, '0));
    ray_queue.push_back(make_ray(mx, mn, mx, mn, mx, mn, mn, mx, mn, '1));
    ray_queue.push_back(make_ray('0, '0, '0, '0, '0, '0, '0, '0, '0, '0));
    // zero direction inside a sphere
    ray_queue.push_back(make_ray('0, '0, '0, '0, '0, '0, '0, '0, '0, 23'h1000));
    // clean hit straight ahead, and the same sphere behind the origin
    ray_queue.push_back(make_ray('0, '0, '0, 24'h1000, '0, '0, 24'h5000, '0, '0, 23'h1000));
    ray_queue.push_back(make_ray('0, '0, '0, -24'sh1000, '0, '0, 24'h5000, '0, '0, 23'h1000));
    // origin inside the sphere
    ray_queue.push_back(make_ray('0, '0, '0, '0, 24'h1000, '0, '0, '0, '0, 23'h3000));
    // tangent ray, zero discriminant
    ray_queue.push_back(make_ray('0, 24'h1000, '0, 24'h1000, '0, '0, 24'h4000, '0, '0,
                                 23'h1000));
    // clear miss, negative discriminant
    ray_queue.push_back(make_ray('0, 24'h8000, '0, 24'h1000, '0, '0, 24'h4000, '0, '0,
                                 23'h1000));
    // tiny direction, far sphere: root saturates high then low
    ray_queue.push_back(make_ray('0, '0, '0, 24'h1, '0, '0, 24'h400000, '0, '0, 23'h1000));
    ray_queue.push_back(make_ray('0, '0, '0, -24'sh1, '0, '0, 24'h400000, '0, '0, 23'h1000));
    // root far behind: negative saturation with origin outside
    ray_queue.push_back(make_ray(24'h7FF000, '0, '0, 24'h1, '0, '0, mn, '0, '0, 23'h1000));
    // inexact division with negative numerator
    ray_queue.push_back(make_ray('0, '0, '0, 24'h3000, 24'h1, '0, -24'sh5123, '0, '0,
                                 23'h1777));
    repeat (RAND_RAYS) ray_queue.push_back(rand_ray());
  end

  // Driver: bursts of words with random gaps, valid held until taken
  always @(posedge clk_i) begin
    ray_t r;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o)
        hit_queue.push_back(nearer_root(make_ray(origin_x_i, origin_y_i, origin_z_i,
                            dir_x_i, dir_y_i, dir_z_i, center_x_i, center_y_i, center_z_i,
                            radius_i)));
      if (!in_valid_i || in_ready_o) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid_i <= 1'b0;
        end else if (ray_queue.size() > 0) begin
          r = ray_queue.pop_front();
          origin_x_i <= r.ox; origin_y_i <= r.oy; origin_z_i <= r.oz;
          dir_x_i <= r.dx; dir_y_i <= r.dy; dir_z_i <= r.dz;
          center_x_i <= r.cx; center_y_i <= r.cy; center_z_i <= r.cz;
          radius_i <= r.rad;
          in_valid_i <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall on a pattern, with one long hold to back up the pipe
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready_i <= 1'b0;
      end else if (!hold_done && results_seen >= 200) begin
        hold_done <= 1'b1;
        hold_left <= 300;
        out_ready_i <= 1'b0;
      end else if ((results_seen / 64) % 2 == 0) begin
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  // Monitor: compare each taken word with the oldest prediction
  always @(posedge clk_i) begin
    hit_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen <= results_seen + 1;
      if (hit_queue.size() == 0) begin
        $display("%0t: unexpected result hit=%0b distance=%0d overflow=%0b",
                 $time, hit_o, distance_o, overflow_o);
        errors++;
      end else begin
        e = hit_queue.pop_front();
        if (hit_o !== e.hit) begin
          $display("%0t: hit expected %0b actual %0b", $time, e.hit, hit_o);
          errors++;
        end
        if (distance_o !== e.depth) begin
          $display("%0t: distance expected %0d actual %0d", $time, e.depth, distance_o);
          errors++;
        end
        if (overflow_o !== e.ovf) begin
          $display("%0t: overflow expected %0b actual %0b", $time, e.ovf, overflow_o);
          errors++;
        end
      end
    end
  end

  // Release reset, drain, then report
  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    while (!(ray_queue.size() == 0 && !in_valid_i && hit_queue.size() == 0))
      @(posedge clk_i);
    repeat (LATENCY + 20) @(posedge clk_i);
    if (errors == 0 && hit_queue.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

endmodule

### ray_sphere_intersect_core.f
hdl/rsi_pkg.sv
hdl/rsi_sqrt_cell.sv
hdl/rsi_div_cell.sv
hdl/ray_sphere_intersect_core.sv
bench/tb_ray_sphere_intersect_core.sv
